>>> src/srup_pkg.sv
// Package of the symmetric rank-2 update unit: register indexes, actions, widths and clipping.
package srup_pkg;

  localparam int DEF_MAX_ORDER = 1024;

  localparam int QW    = 32;  // Q16.16 word
  localparam int IDXW  = 10;  // row and column index fields
  localparam int SIZEW = 11;  // matrix_size register
  localparam int CFGW  = 2;   // configuration register index
  localparam int SUMW  = 50;  // a plus two 48-bit products

  localparam logic [CFGW-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFGW-1:0] CFG_LOWER = 2'd1;
  localparam logic [CFGW-1:0] CFG_SIZE  = 2'd2;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  localparam logic [SIZEW-1:0] SIZE_RESET = 11'd1024;

  // Clips a signed value to the Q16.16 range; bit 32 of the result flags clipping.
  function automatic logic [QW:0] clip_q(input logic signed [SUMW-1:0] v);
    logic [SUMW-QW:0] top;
    logic [QW:0]      res;
    top = v[SUMW-1:QW-1];
    if ((top == '0) || (top == '1)) begin
      res = {1'b0, v[QW-1:0]};
    end else if (v[SUMW-1]) begin
      res = {1'b1, 1'b1, {(QW-1){1'b0}}};
    end else begin
      res = {1'b1, 1'b0, {(QW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

>>> src/srup_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module srup_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> src/symmetric_rank2_update_unit.sv
// Symmetric rank-2 update unit: vector store and five-stage Q16.16 update pipeline.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  s_*     | in        | s_tvalid / s_tready   | s_tuser: action; s_tdata: indices, x, y, a
//  m_*     | out       | m_tvalid / m_tready   | m_tuser: flags; m_tdata: updated_value
//  cfg_*   | in        | cfg_we                | cfg_index, cfg_data
//
// One word is accepted per cycle unless stalled; update results pass through every stage.
// The stages are: vector RAM read, alpha products, clip, row products, sum and clip.
// All stages advance together whenever the output register is empty or being taken.
// Loads write the vector RAM at acceptance and produce no result.
// Reset zeroes valid bits, alpha, lower_triangle; matrix_size is 1024; RAM is not cleared.
module symmetric_rank2_update_unit
  import srup_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // [0] action
  input  logic [0:0]    s_tuser,
  // [9:0] row_index, [19:10] col_index, [51:20] x_value, [83:52] y_value,
  // [115:84] matrix_value, [119:116] zero
  input  logic [119:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // [0] was_changed, [1] saturated
  output logic [1:0]    m_tuser,
  // [31:0] updated_value
  output logic [31:0]   m_tdata,
  input  logic          cfg_we,
  input  logic [CFGW-1:0] cfg_index,
  input  logic [QW-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ORDER);
  localparam int IW = (AW > IDXW) ? AW : IDXW;
  localparam int CW = ($clog2(MAX_ORDER + 1) > SIZEW) ? $clog2(MAX_ORDER + 1) : SIZEW;

  // Configuration registers.
  logic signed [QW-1:0] alpha;
  logic                 lower_triangle;
  logic [SIZEW-1:0]     matrix_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha          <= '0;
      lower_triangle <= 1'b0;
      matrix_size    <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA: alpha          <= cfg_data;
        CFG_LOWER: lower_triangle <= cfg_data[0];
        CFG_SIZE:  matrix_size    <= cfg_data[SIZEW-1:0];
        default: ;
      endcase
    end
  end

  // Input word fields.
  logic                 in_action;
  logic [IDXW-1:0]      in_row;
  logic [IDXW-1:0]      in_col;
  logic [QW-1:0]        in_x;
  logic [QW-1:0]        in_y;
  logic [QW-1:0]        in_a;

  assign in_action = s_tuser[0];
  assign in_row    = s_tdata[9:0];
  assign in_col    = s_tdata[19:10];
  assign in_x      = s_tdata[51:20];
  assign in_y      = s_tdata[83:52];
  assign in_a      = s_tdata[115:84];

  logic advance;
  logic accept;
  logic v1, v2, v3, v4, v5;

  assign advance  = !v5 || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && advance;

  // Index compare against the effective order, min(matrix_size, MAX_ORDER).
  logic [CW-1:0] size_w;
  logic [CW-1:0] order_n;
  logic [CW-1:0] row_c;
  logic [CW-1:0] col_c;
  logic          in_tri;
  logic          inside0;
  logic          load_ok;
  logic [IW-1:0] row_w;
  logic [IW-1:0] col_w;

  always_comb begin
    size_w  = CW'(matrix_size);
    order_n = (size_w < CW'(MAX_ORDER)) ? size_w : CW'(MAX_ORDER);
    row_c   = CW'(in_row);
    col_c   = CW'(in_col);
    in_tri  = lower_triangle ? (in_row >= in_col) : (in_row <= in_col);
    inside0 = (row_c < order_n) && (col_c < order_n) && in_tri;
    load_ok = row_c < CW'(MAX_ORDER);
    row_w   = IW'(in_row);
    col_w   = IW'(in_col);
  end

  // Vector RAM: x in the upper half of a word, y in the lower half.
  logic [2*QW-1:0] rd_row;
  logic [2*QW-1:0] rd_col;

  srup_ram #(
    .WIDTH (2*QW),
    .DEPTH (MAX_ORDER)
  ) u_vec_ram (
    .clk     (clk),
    .we      (accept && (in_action == ACT_LOAD) && load_ok),
    .waddr   (row_w[AW-1:0]),
    .wdata   ({in_x, in_y}),
    .re      (advance),
    .raddr_a (row_w[AW-1:0]),
    .raddr_b (col_w[AW-1:0]),
    .rdata_a (rd_row),
    .rdata_b (rd_col)
  );

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid && (in_action == ACT_UPDATE);
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage payloads.
  logic [QW-1:0]          a1, a2, a3, a4, a5;
  logic                   in1, in2, in3, in4;
  logic signed [QW-1:0]   xr2, yr2, xr3, yr3;
  logic signed [2*QW-1:0] pay2, pax2;
  logic signed [QW-1:0]   t1_3, t2_3;
  logic                   sat3, sat4;
  logic signed [2*QW-1:0] p1_4, p2_4;
  logic [QW-1:0]          res5;
  logic                   chg5, sat5;

  logic signed [QW-1:0]   xr1, yr1, xc1, yc1;
  logic [QW:0]            c1, c2, cs;
  logic signed [SUMW-1:0] sum4;

  always_comb begin
    xr1  = rd_row[2*QW-1:QW];
    yr1  = rd_row[QW-1:0];
    xc1  = rd_col[2*QW-1:QW];
    yc1  = rd_col[QW-1:0];
    // Dropping the low 16 bits of a two's complement product rounds toward minus infinity.
    c1   = clip_q(SUMW'($signed(pay2[2*QW-1:16])));
    c2   = clip_q(SUMW'($signed(pax2[2*QW-1:16])));
    sum4 = SUMW'($signed(a4)) + SUMW'($signed(p1_4[2*QW-1:16]))
         + SUMW'($signed(p2_4[2*QW-1:16]));
    cs   = clip_q(sum4);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a1  <= in_a;
      in1 <= inside0;
    end
    if (advance) begin
      a2   <= a1;
      in2  <= in1;
      xr2  <= xr1;
      yr2  <= yr1;
      pay2 <= alpha * yc1;
      pax2 <= alpha * xc1;

      a3   <= a2;
      in3  <= in2;
      xr3  <= xr2;
      yr3  <= yr2;
      t1_3 <= c1[QW-1:0];
      t2_3 <= c2[QW-1:0];
      sat3 <= c1[QW] || c2[QW];

      a4   <= a3;
      in4  <= in3;
      sat4 <= sat3;
      p1_4 <= xr3 * t1_3;
      p2_4 <= yr3 * t2_3;

      a5   <= a4;
      chg5 <= in4;
      if (in4) begin
        res5 <= cs[QW-1:0];
        sat5 <= sat4 || cs[QW];
      end else begin
        res5 <= a4;
        sat5 <= 1'b0;
      end
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = res5;
  assign m_tuser  = {sat5, chg5};

`ifndef SYNTHESIS
  a_unchanged_not_sat: assert property (@(posedge clk) disable iff (rst)
    (v5 && !chg5) |-> !sat5)
    else $error("saturation flagged on an element outside the triangle");

  a_unchanged_passes: assert property (@(posedge clk) disable iff (rst)
    (v5 && !chg5) |-> (res5 == a5))
    else $error("element outside the triangle was modified");

  a_update_enters: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_action == ACT_UPDATE)) |=> v1)
    else $error("accepted update word lost at pipeline entry");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !advance) |=> v4)
    else $error("stalled pipeline dropped a word");
`endif

endmodule
